// ===== rtl/e2q_pkg.sv =====
package e2q_pkg;

   // cordic geometry
   localparam int CORDIC_STAGES = 30;
   localparam int CORDIC_W      = 34;
   localparam int ZW            = 34;
   localparam int PROD_W        = 32;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   // doubled arctangent table, 32-bit turn units
   function automatic logic signed [ZW-1:0] atan2x(input int idx);
      logic signed [ZW-1:0] t;
      begin
         case (idx)
            0:  t = 34'sd536870912;
            1:  t = 34'sd316933406;
            2:  t = 34'sd167458907;
            3:  t = 34'sd85004756;
            4:  t = 34'sd42667331;
            5:  t = 34'sd21354465;
            6:  t = 34'sd10679838;
            7:  t = 34'sd5340245;
            8:  t = 34'sd2670163;
            9:  t = 34'sd1335087;
            10: t = 34'sd667544;
            11: t = 34'sd333772;
            12: t = 34'sd166886;
            13: t = 34'sd83443;
            14: t = 34'sd41722;
            15: t = 34'sd20861;
            16: t = 34'sd10430;
            17: t = 34'sd5215;
            18: t = 34'sd2608;
            19: t = 34'sd1304;
            20: t = 34'sd652;
            21: t = 34'sd326;
            22: t = 34'sd163;
            23: t = 34'sd81;
            24: t = 34'sd41;
            25: t = 34'sd20;
            26: t = 34'sd10;
            27: t = 34'sd5;
            28: t = 34'sd3;
            29: t = 34'sd1;
            default: t = '0;
         endcase
         return t <<< 1;
      end
   endfunction

   // cosine and sine of one half angle, q30
   typedef struct packed {
      logic signed [CORDIC_W-1:0] c;
      logic signed [CORDIC_W-1:0] s;
   } sincos_type;

endpackage

// ===== rtl/e2q_cordic_lane.sv =====
module e2q_cordic_lane #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic signed [ANGLE_BITS-1:0]  angle,
   output e2q_pkg::sincos_type           result
);
   import e2q_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff [CORDIC_STAGES+1];
   logic signed [CORDIC_W-1:0] y_ff [CORDIC_STAGES+1];
   logic signed [ZW-1:0]       z_ff [CORDIC_STAGES+1];

   // load stage, angle scaled to a 32-bit turn
   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0] <= CORDIC_GAIN_Q30;
         y_ff[0] <= '0;
         z_ff[0] <= ZW'(angle) <<< (32 - ANGLE_BITS);
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (enable) begin
            if (!z_ff[i][ZW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan2x(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan2x(i);
            end
         end
      end
   end

   assign result.c = x_ff[CORDIC_STAGES];
   assign result.s = y_ff[CORDIC_STAGES];

endmodule

// ===== rtl/e2q_merge.sv =====
module e2q_merge #(
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                             clock,
   input  logic                             enable,
   input  e2q_pkg::sincos_type              roll,
   input  e2q_pkg::sincos_type              pitch,
   input  e2q_pkg::sincos_type              yaw,
   output logic signed [OUT_FRAC_BITS+1:0]  quat_w,
   output logic signed [OUT_FRAC_BITS+1:0]  quat_x,
   output logic signed [OUT_FRAC_BITS+1:0]  quat_y,
   output logic signed [OUT_FRAC_BITS+1:0]  quat_z
);
   import e2q_pkg::*;

   localparam int OW = OUT_FRAC_BITS + 2;
   localparam int SH = 30 - OUT_FRAC_BITS;
   localparam int MW = 2 * PROD_W;

   // rounded q30 product, operands never exceed 32 signed bits
   function automatic logic signed [CORDIC_W-1:0] mulq(
      input logic signed [CORDIC_W-1:0] a, input logic signed [CORDIC_W-1:0] b);
      logic signed [PROD_W-1:0] an;
      logic signed [PROD_W-1:0] bn;
      logic signed [MW-1:0]     p;
      begin
         an = PROD_W'(a);
         bn = PROD_W'(b);
         p  = (MW'(an) * MW'(bn)) + (MW'(1) <<< 29);
         return CORDIC_W'(p >>> 30);
      end
   endfunction

   function automatic logic signed [OW-1:0] outq(input logic signed [CORDIC_W:0] v);
      logic signed [CORDIC_W:0] r;
      logic signed [CORDIC_W:0] lim;
      begin
         lim = (CORDIC_W+1)'(1) <<< OUT_FRAC_BITS;
         if (SH == 0) r = v;
         else         r = (v + ((CORDIC_W+1)'(1) <<< (SH - 1))) >>> SH;
         if (r > lim)       r = lim;
         else if (r < -lim) r = -lim;
         return OW'(r);
      end
   endfunction

   // pair products: cr*cp, sr*cp, cr*sp, sr*sp
   logic signed [CORDIC_W-1:0] cc_ff, sc_ff, cs_ff, ss_ff;
   logic signed [CORDIC_W-1:0] cy_ff, sy_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         cc_ff <= mulq(roll.c, pitch.c);
         sc_ff <= mulq(roll.s, pitch.c);
         cs_ff <= mulq(roll.c, pitch.s);
         ss_ff <= mulq(roll.s, pitch.s);
         cy_ff <= yaw.c;
         sy_ff <= yaw.s;
      end
   end

   // triple products
   logic signed [CORDIC_W-1:0] t_ff [8];
   always_ff @(posedge clock) begin
      if (enable) begin
         t_ff[0] <= mulq(cc_ff, cy_ff);
         t_ff[1] <= mulq(ss_ff, sy_ff);
         t_ff[2] <= mulq(sc_ff, cy_ff);
         t_ff[3] <= mulq(cs_ff, sy_ff);
         t_ff[4] <= mulq(cs_ff, cy_ff);
         t_ff[5] <= mulq(sc_ff, sy_ff);
         t_ff[6] <= mulq(cc_ff, sy_ff);
         t_ff[7] <= mulq(ss_ff, cy_ff);
      end
   end

   // sums, rounding and clamp
   logic signed [OW-1:0] quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         quat_w_ff <= outq((CORDIC_W+1)'(t_ff[0]) + (CORDIC_W+1)'(t_ff[1]));
         quat_x_ff <= outq((CORDIC_W+1)'(t_ff[2]) - (CORDIC_W+1)'(t_ff[3]));
         quat_y_ff <= outq((CORDIC_W+1)'(t_ff[4]) + (CORDIC_W+1)'(t_ff[5]));
         quat_z_ff <= outq((CORDIC_W+1)'(t_ff[6]) - (CORDIC_W+1)'(t_ff[7]));
      end
   end

   assign quat_w = quat_w_ff;
   assign quat_x = quat_x_ff;
   assign quat_y = quat_y_ff;
   assign quat_z = quat_z_ff;

endmodule

// ===== rtl/euler_to_quaternion_unit.sv =====
// channel  | direction | ports
// request  | in        | req_valid, req_stall, req_roll/pitch/yaw_angle
// result   | out       | rsp_valid, rsp_stall, rsp_quat_w/x/y/z
//
// one request per cycle while the pipeline is not stalled; stages: load, 30 cordic stages per
// lane, pair product, triple product, output round
// reset clears only the stage valid bits; data registers are not reset
// a stall on the result side freezes the whole pipeline, so req_stall
// follows rsp_stall while the output stage holds a result
module euler_to_quaternion_unit #(
   parameter int ANGLE_BITS    = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [ANGLE_BITS-1:0]    req_roll_angle,
   input  logic signed [ANGLE_BITS-1:0]    req_pitch_angle,
   input  logic signed [ANGLE_BITS-1:0]    req_yaw_angle,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_quat_w,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_quat_x,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_quat_y,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_quat_z
);
   import e2q_pkg::*;

   localparam int DEPTH = CORDIC_STAGES + 4;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             enable;
   sincos_type       sc_roll, sc_pitch, sc_yaw;

   // pipeline moves unless a finished result is held
   assign enable    = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !enable;
   assign rsp_valid = vld_ff[DEPTH-1];
   assign vld_in    = {vld_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (enable) vld_ff <= vld_in;
   end

   // three cordic lanes
   e2q_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
      .clock(clock), .enable(enable), .angle(req_roll_angle), .result(sc_roll));
   e2q_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
      .clock(clock), .enable(enable), .angle(req_pitch_angle), .result(sc_pitch));
   e2q_cordic_lane #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
      .clock(clock), .enable(enable), .angle(req_yaw_angle), .result(sc_yaw));

   // merge into quaternion
   e2q_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
      .clock(clock), .enable(enable),
      .roll(sc_roll), .pitch(sc_pitch), .yaw(sc_yaw),
      .quat_w(rsp_quat_w), .quat_x(rsp_quat_x),
      .quat_y(rsp_quat_y), .quat_z(rsp_quat_z));

endmodule

// ===== rtl/e2q_checker.sv =====
module e2q_checker #(
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic signed [OUT_FRAC_BITS+1:0] rsp_quat_w,
   input  logic signed [OUT_FRAC_BITS+1:0] rsp_quat_x
);
   localparam logic signed [OUT_FRAC_BITS+1:0] LIM = (OUT_FRAC_BITS+2)'(1) <<< OUT_FRAC_BITS;

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // w and x outputs stay within unit range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_quat_w <= LIM && rsp_quat_w >= -LIM
                     && rsp_quat_x <= LIM && rsp_quat_x >= -LIM))
      else $error("quaternion out of range");

   // request side stalls only when a result is held back
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without cause");

   // held result keeps its w value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_quat_w)))
      else $error("held result changed");

endmodule

bind euler_to_quaternion_unit e2q_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_e2q_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x));

// ===== dv/quat_checker.sv =====
module quat_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_yaw_angle,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_quat_w,
   input  logic signed [15:0] rsp_quat_x,
   input  logic signed [15:0] rsp_quat_y,
   input  logic signed [15:0] rsp_quat_z,
   output int                 fail_count,
   output int                 pending_quats
);

   localparam int OUT_FRAC = 14;

   typedef struct {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   quat_type expected_quats[$];

   // floor shift right of a signed value
   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_shr(longint v, int s);
      if (s == 0) return v;
      return floor_shr(v + (longint'(1) << (s - 1)), s);
   endfunction

   function automatic longint mul30(longint a, longint b);
      return round_shr(a * b, 30);
   endfunction

   function automatic longint atan_step(int i);
      longint t [30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                         21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                         333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                         1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};
      return t[i];
   endfunction

   // half-angle cosine and sine by rotation-mode cordic, q30
   task automatic half_angle_sincos(input logic signed [15:0] ang,
                                    output longint c, output longint s);
      longint cx, sy, res, dx, dy;
      cx  = 652032874;
      sy  = 0;
      res = longint'(ang) * 65536;
      for (int i = 0; i < 30; i++) begin
         dx = floor_shr(sy, i);
         dy = floor_shr(cx, i);
         if (res >= 0) begin
            cx -= dx; sy += dy; res -= 2 * atan_step(i);
         end else begin
            cx += dx; sy -= dy; res += 2 * atan_step(i);
         end
      end
      c = cx;
      s = sy;
   endtask

   function automatic logic signed [15:0] to_q14(longint q30);
      longint v;
      v = round_shr(q30, 30 - OUT_FRAC);
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return v[15:0];
   endfunction

   function automatic longint trip(longint a, longint b, longint c);
      return mul30(mul30(a, b), c);
   endfunction

   task automatic predict_quat(input logic signed [15:0] r, p, y, output quat_type q);
      longint cr, sr, cp, sp, cy, sy;
      half_angle_sincos(r, cr, sr);
      half_angle_sincos(p, cp, sp);
      half_angle_sincos(y, cy, sy);
      q.w = to_q14(trip(cr, cp, cy) + trip(sr, sp, sy));
      q.x = to_q14(trip(sr, cp, cy) - trip(cr, sp, sy));
      q.y = to_q14(trip(cr, sp, cy) + trip(sr, cp, sy));
      q.z = to_q14(trip(cr, cp, sy) - trip(sr, sp, cy));
   endtask

   assign pending_quats = expected_quats.size();

   initial fail_count = 0;

   // predict on each accepted request, compare on each accepted result
   always @(posedge clock) begin
      quat_type q, e;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_quat(req_roll_angle, req_pitch_angle, req_yaw_angle, q);
            expected_quats.push_back(q);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_quats.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result w=%0d x=%0d y=%0d z=%0d",
                           rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
            end else begin
               e = expected_quats.pop_front();
               if (e.w !== rsp_quat_w || e.x !== rsp_quat_x ||
                   e.y !== rsp_quat_y || e.z !== rsp_quat_z) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch exp w=%0d x=%0d y=%0d z=%0d got %0d %0d %0d %0d",
                              e.w, e.x, e.y, e.z,
                              rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
               end
            end
         end
      end
   end

endmodule

// ===== dv/testbench.sv =====
module testbench;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_roll_angle = '0;
   logic signed [15:0] req_pitch_angle = '0;
   logic signed [15:0] req_yaw_angle = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   int                 fail_count;
   int                 pending_quats;
   bit                 calm = 1'b0;

   always #5 clock = ~clock;

   euler_to_quaternion_unit i_dut (.*);

   quat_checker i_checker (.*);

   // one request, with optional idle cycles before it
   task automatic send_request(input logic signed [15:0] r, p, y);
      if (!calm) begin
         while ($urandom_range(99) < 28) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_roll_angle  <= r;
      req_pitch_angle <= p;
      req_yaw_angle   <= y;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic signed [15:0] pick_angle();
      logic signed [15:0] corners [8] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff,
                                          16'sh0001, 16'sh4000, 16'shc000, 16'sh2000};
      if ($urandom_range(9) == 0) return corners[$urandom_range(7)];
      return 16'($urandom());
   endfunction

   // result side stall
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else       rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 28);
   end

   initial begin
      int wait_cycles;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes and quarter turns on each axis
      send_request(16'sh0000, 16'sh0000, 16'sh0000);
      send_request(16'sh8000, 16'sh8000, 16'sh8000);
      send_request(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_request(16'sh8000, 16'sh0000, 16'sh0000);
      send_request(16'sh0000, 16'sh8000, 16'sh0000);
      send_request(16'sh0000, 16'sh0000, 16'sh8000);
      send_request(16'sh4000, 16'sh0000, 16'sh0000);
      send_request(16'sh0000, 16'sh4000, 16'sh0000);
      send_request(16'sh0000, 16'sh0000, 16'sh4000);
      send_request(16'shc000, 16'shc000, 16'shc000);
      send_request(16'shffff, 16'shffff, 16'shffff);
      send_request(16'sh0001, 16'sh0001, 16'sh0001);
      send_request(16'sh5555, 16'shaaaa, 16'sh7fff);
      send_request(16'shaaaa, 16'sh5555, 16'sh8000);
      send_request(16'sh2000, 16'sh4000, 16'sh6000);
      // random, with a stretch of full throughput in the middle
      for (int n = 0; n < 1350; n++) begin
         calm = (n >= 500 && n < 700);
         send_request(pick_angle(), pick_angle(), pick_angle());
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (pending_quats != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_quats == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
